>>> src/path_nearest_segment_search_unit_macros.svh
// Assertion macros used by the checker file of the path search unit.
`ifndef PATH_NEAREST_SEGMENT_SEARCH_UNIT_MACROS_SVH
`define PATH_NEAREST_SEGMENT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pnss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PNSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pnss assertion failed");

`endif

>>> src/pnss_pkg.sv
// Package of the path search unit: payload types, codes, constants, helpers.
package pnss_pkg;

  localparam int PNSS_MAX_POINTS = 256;
  localparam int PNSS_LEN_W      = 9;
  localparam int PNSS_CFG_IDX_W  = 2;
  localparam int PNSS_SQ_W       = 64;
  localparam int PNSS_DIST_W     = 65;

  localparam logic signed [31:0] PNSS_MIN_VAL = 32'sh8000_0000;
  localparam logic signed [31:0] PNSS_MAX_VAL = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_QUERY   = 2'd1,
    FUNC_RESTART = 2'd2
  } pnss_func_e;

  typedef enum logic [PNSS_CFG_IDX_W-1:0] {
    CFG_PATH_LENGTH   = 2'd0,
    CFG_REVERSE_ORDER = 2'd1,
    CFG_MIRROR        = 2'd2
  } pnss_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ_X,
    ST_SQ_Y,
    ST_CMP,
    ST_DECIDE,
    ST_EMIT0,
    ST_EMIT1
  } pnss_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_heading;
  } pnss_req_t;

  typedef struct packed {
    logic               found;
    logic               is_last;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_heading;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_heading;
  } pnss_res_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_heading;
  } pnss_point_t;

  localparam int PNSS_POINT_W = $bits(pnss_point_t);

  typedef struct packed {
    logic [PNSS_LEN_W-1:0] path_length;
    logic                  reverse_order;
    logic                  mirror;
  } pnss_cfg_t;

  function automatic logic signed [31:0] pnss_neg_sat(input logic signed [31:0] v);
    return (v == PNSS_MIN_VAL) ? PNSS_MAX_VAL : -v;
  endfunction

  function automatic pnss_point_t pnss_mirror(input pnss_point_t p, input logic m);
    pnss_point_t r;
    r = p;
    if (m) begin
      r.x           = pnss_neg_sat(p.x);
      r.heading     = pnss_neg_sat(p.heading);
      r.vel_x       = pnss_neg_sat(p.vel_x);
      r.vel_heading = pnss_neg_sat(p.vel_heading);
    end
    return r;
  endfunction

endpackage

>>> src/path_nearest_segment_search_unit.sv
// Top level of the path search unit: configuration registers and unit wiring.
// Load and restart requests leave busy_o low.
// A query holds busy_o through its scan, its decision and, on a hit, its first result;
// when nothing is scanned it goes straight to decide; each point takes x square, y square, compare.
// Results appear on res_valid_o in consecutive cycles, the last one as busy_o falls; no stall.
// Reset clears configuration and search start to zero; path storage is not cleared.
module path_nearest_segment_search_unit #(
  parameter int MAX_POINTS = pnss_pkg::PNSS_MAX_POINTS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  pnss_pkg::pnss_req_t                     req_i,
  output logic                                    res_valid_o,
  output pnss_pkg::pnss_res_t                     res_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pnss_pkg::PNSS_CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pnss_pkg::PNSS_LEN_W-1:0]         cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);

  pnss_pkg::pnss_cfg_t cfg_q, cfg_d;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [pnss_pkg::PNSS_POINT_W-1:0]  ram_wdata;
  logic                               ram_re;
  logic [AW-1:0]                      ram_raddr;
  logic [pnss_pkg::PNSS_POINT_W-1:0]  ram_rdata;
  logic                               sq_en;
  logic signed [31:0]                 sq_a;
  logic signed [31:0]                 sq_b;
  logic [pnss_pkg::PNSS_SQ_W-1:0]     sq;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pnss_pkg::CFG_PATH_LENGTH:   cfg_d.path_length   = cfg_data_i;
        pnss_pkg::CFG_REVERSE_ORDER: cfg_d.reverse_order = cfg_data_i[0];
        pnss_pkg::CFG_MIRROR:        cfg_d.mirror        = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pnss_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .sq_en_o     (sq_en),
    .sq_a_o      (sq_a),
    .sq_b_o      (sq_b),
    .sq_i        (sq)
  );

  pnss_ram #(
    .WIDTH (pnss_pkg::PNSS_POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pnss_sq_unit u_sq (
    .clk_i (clk_i),
    .en_i  (sq_en),
    .a_i   (sq_a),
    .b_i   (sq_b),
    .sq_o  (sq)
  );

endmodule

>>> src/pnss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pnss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pnss_sq_unit.sv
// Shared square unit: absolute difference of two coordinates, squared, registered.
module pnss_sq_unit (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [31:0]                  a_i,
  input  logic signed [31:0]                  b_i,
  output logic [pnss_pkg::PNSS_SQ_W-1:0]      sq_o
);

  logic [32:0]                       diff;
  logic [32:0]                       mag_w;
  logic [31:0]                       mag;
  logic [pnss_pkg::PNSS_SQ_W-1:0]    sq_d;
  logic [pnss_pkg::PNSS_SQ_W-1:0]    sq_q;

  always_comb begin
    diff  = {a_i[31], a_i} - {b_i[31], b_i};
    mag_w = diff[32] ? (~diff + 33'd1) : diff;
    // magnitude of two 32-bit signed values always fits 32 unsigned bits
    mag   = mag_w[31:0];
    sq_d  = 64'(mag) * 64'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

>>> src/pnss_ctrl.sv
// Sequencer: request decode, path scan, nearest pair tracking and result output.
module pnss_ctrl #(
  parameter int MAX_POINTS = pnss_pkg::PNSS_MAX_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  pnss_pkg::pnss_req_t                 req_i,
  input  pnss_pkg::pnss_cfg_t                 cfg_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  output pnss_pkg::pnss_res_t                 res_o,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_POINTS)-1:0]       ram_waddr_o,
  output logic [pnss_pkg::PNSS_POINT_W-1:0]   ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(MAX_POINTS)-1:0]       ram_raddr_o,
  input  logic [pnss_pkg::PNSS_POINT_W-1:0]   ram_rdata_i,
  output logic                                sq_en_o,
  output logic signed [31:0]                  sq_a_o,
  output logic signed [31:0]                  sq_b_o,
  input  logic [pnss_pkg::PNSS_SQ_W-1:0]      sq_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = $clog2(MAX_POINTS + 1);
  localparam int DW = pnss_pkg::PNSS_DIST_W;

  pnss_pkg::pnss_state_e state_q, state_d;

  logic [IW-1:0]                   start_q, start_d;
  logic [IW-1:0]                   i_q, i_d;
  logic [IW-1:0]                   i1_q, i1_d;
  logic [IW-1:0]                   i2_q, i2_d;
  logic                            v1_q, v1_d;
  logic                            v2_q, v2_d;
  logic [DW-1:0]                   d1_q, d1_d;
  logic [DW-1:0]                   d2_q, d2_d;
  logic [pnss_pkg::PNSS_SQ_W-1:0]  sqx_q, sqx_d;
  logic signed [31:0]              rx_q, rx_d;
  logic signed [31:0]              ry_q, ry_d;
  logic                            res_valid_q, res_valid_d;
  pnss_pkg::pnss_res_t             res_q, res_d;

  logic [IW-1:0]        n_len;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        i_next;
  logic [IW-1:0]        lo;
  logic [DW-1:0]        pt_dist;
  logic                 lt1;
  logic                 lt2;
  pnss_pkg::pnss_point_t pt_m;
  pnss_pkg::pnss_point_t wr_pt;

  assign n_len = (32'(cfg_i.path_length) > 32'(MAX_POINTS)) ? IW'(MAX_POINTS)
                                                            : IW'(cfg_i.path_length);
  assign i_next  = i_q + IW'(1);
  assign lo      = (i1_q < i2_q) ? i1_q : i2_q;
  assign pt_dist = {1'b0, sqx_q} + {1'b0, sq_i};
  assign lt1     = !v1_q || (pt_dist < d1_q);
  assign lt2     = !v2_q || (pt_dist < d2_q);
  assign pt_m    = pnss_pkg::pnss_mirror(pnss_pkg::pnss_point_t'(ram_rdata_i), cfg_i.mirror);

  always_comb begin
    wr_pt.x           = req_i.pos_x;
    wr_pt.y           = req_i.pos_y;
    wr_pt.heading     = req_i.heading;
    wr_pt.vel_x       = req_i.vel_x;
    wr_pt.vel_y       = req_i.vel_y;
    wr_pt.vel_heading = req_i.vel_heading;
  end

  assign ram_wdata_o = wr_pt;
  assign ram_waddr_o = AW'(req_i.entry_index);

  // Read address: scan position, or the lower pair index when deciding, mapped through the walk direction.
  always_comb begin
    case (state_q)
      pnss_pkg::ST_CMP, pnss_pkg::ST_EMIT0: rd_idx = i_next;
      pnss_pkg::ST_DECIDE:                  rd_idx = lo;
      default:                              rd_idx = i_q;
    endcase
    ram_raddr_o = cfg_i.reverse_order ? AW'(n_len - IW'(1) - rd_idx) : AW'(rd_idx);
    ram_re_o    = (state_q == pnss_pkg::ST_READ) || (state_q == pnss_pkg::ST_CMP) ||
                  (state_q == pnss_pkg::ST_DECIDE) || (state_q == pnss_pkg::ST_EMIT0);
  end

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    i_d         = i_q;
    i1_d        = i1_q;
    i2_d        = i2_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    sqx_d       = sqx_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    sq_en_o     = 1'b0;
    sq_a_o      = rx_q;
    sq_b_o      = pt_m.x;

    case (state_q)
      pnss_pkg::ST_IDLE: begin
        if (start_i) begin
          case (req_i.func)
            pnss_pkg::FUNC_LOAD: begin
              ram_we_o = (32'(req_i.entry_index) < 32'(MAX_POINTS));
            end
            pnss_pkg::FUNC_RESTART: begin
              start_d = '0;
            end
            pnss_pkg::FUNC_QUERY: begin
              rx_d    = req_i.pos_x;
              ry_d    = req_i.pos_y;
              i_d     = start_q;
              v1_d    = 1'b0;
              v2_d    = 1'b0;
              state_d = (start_q < n_len) ? pnss_pkg::ST_READ : pnss_pkg::ST_DECIDE;
            end
            default: ;
          endcase
        end
      end
      pnss_pkg::ST_READ: begin
        state_d = pnss_pkg::ST_SQ_X;
      end
      pnss_pkg::ST_SQ_X: begin
        sq_en_o = 1'b1;
        state_d = pnss_pkg::ST_SQ_Y;
      end
      pnss_pkg::ST_SQ_Y: begin
        sq_en_o = 1'b1;
        sq_a_o  = ry_q;
        sq_b_o  = pt_m.y;
        sqx_d   = sq_i;
        state_d = pnss_pkg::ST_CMP;
      end
      pnss_pkg::ST_CMP: begin
        // earlier point keeps its rank on equal distance
        if (lt1) begin
          v2_d = v1_q;
          i2_d = i1_q;
          d2_d = d1_q;
          v1_d = 1'b1;
          i1_d = i_q;
          d1_d = pt_dist;
        end else if (lt2) begin
          v2_d = 1'b1;
          i2_d = i_q;
          d2_d = pt_dist;
        end
        i_d     = i_next;
        state_d = (i_next < n_len) ? pnss_pkg::ST_SQ_X : pnss_pkg::ST_DECIDE;
      end
      pnss_pkg::ST_DECIDE: begin
        if (!(v1_q && v2_q)) begin
          start_d       = '0;
          res_valid_d   = 1'b1;
          res_d         = '0;
          res_d.is_last = 1'b1;
          state_d       = pnss_pkg::ST_IDLE;
        end else begin
          start_d = lo;
          i_d     = lo;
          // drop pairs whose lower index plus two reaches the path length
          if ((IW+1)'(lo) + (IW+1)'(2) >= (IW+1)'(n_len)) begin
            res_valid_d   = 1'b1;
            res_d         = '0;
            res_d.is_last = 1'b1;
            state_d       = pnss_pkg::ST_IDLE;
          end else begin
            state_d = pnss_pkg::ST_EMIT0;
          end
        end
      end
      pnss_pkg::ST_EMIT0: begin
        res_valid_d           = 1'b1;
        res_d.found           = 1'b1;
        res_d.is_last         = 1'b0;
        res_d.out_x           = pt_m.x;
        res_d.out_y           = pt_m.y;
        res_d.out_heading     = pt_m.heading;
        res_d.out_vel_x       = pt_m.vel_x;
        res_d.out_vel_y       = pt_m.vel_y;
        res_d.out_vel_heading = pt_m.vel_heading;
        state_d               = pnss_pkg::ST_EMIT1;
      end
      pnss_pkg::ST_EMIT1: begin
        res_valid_d           = 1'b1;
        res_d.found           = 1'b1;
        res_d.is_last         = 1'b1;
        res_d.out_x           = pt_m.x;
        res_d.out_y           = pt_m.y;
        res_d.out_heading     = pt_m.heading;
        res_d.out_vel_x       = pt_m.vel_x;
        res_d.out_vel_y       = pt_m.vel_y;
        res_d.out_vel_heading = pt_m.vel_heading;
        state_d               = pnss_pkg::ST_IDLE;
      end
      default: begin
        state_d = pnss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnss_pkg::ST_IDLE;
      start_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    i1_q  <= i1_d;
    i2_q  <= i2_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    sqx_q <= sqx_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != pnss_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/pnss_checker.sv
// Port-level checker for the path search unit, bound to the top level.
`include "path_nearest_segment_search_unit_macros.svh"

module pnss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input pnss_pkg::pnss_req_t req_i,
  input logic                res_valid_o,
  input pnss_pkg::pnss_res_t res_o
);

  logic query_acc;
  logic other_acc;
  logic first_res;
  logic miss_res;
  logic miss_zero;

  assign query_acc = start_i && !busy_o && (req_i.func == pnss_pkg::FUNC_QUERY);
  assign other_acc = start_i && !busy_o && (req_i.func != pnss_pkg::FUNC_QUERY);
  assign first_res = res_valid_o && !res_o.is_last;
  assign miss_res  = res_valid_o && !res_o.found;
  assign miss_zero = res_o.is_last && (res_o.out_x == '0) && (res_o.out_y == '0) &&
                     (res_o.out_heading == '0) && (res_o.out_vel_x == '0) &&
                     (res_o.out_vel_y == '0) && (res_o.out_vel_heading == '0);

  // A query occupies the unit for its scan.
  `PNSS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_acc, busy_o)
  // Loads, restarts and unused codes never occupy the unit.
  `PNSS_ASSERT_NEXT(a_other_idle, clk_i, rst_ni, other_acc, !busy_o)
  // The first point of a pair is followed at once by its successor.
  `PNSS_ASSERT_NEXT(a_pair_next, clk_i, rst_ni, first_res,
                    res_valid_o && res_o.is_last && res_o.found)
  // A miss is a single, all-zero final result.
  `PNSS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, miss_res, miss_zero)

endmodule

bind path_nearest_segment_search_unit pnss_checker u_pnss_checker (.*);
